[design/afc_pkg.sv]
// Shared types, widths and constant tables for the ALE flux correction block.
// Used by the divider, multiplier, geometry store and top level; no dependencies.
`timescale 1ns / 1ps

package afc_pkg;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 64;
    localparam int GEO_DEPTH = 13;
    localparam int SLOT_W    = 4;
    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 96;

    typedef logic [SLOT_W-1:0] slot_t;

    localparam slot_t SLOT_G = 4'd9;
    localparam slot_t SLOT_V = 4'd10;

    // Configuration register indexes and their codes.
    localparam logic CFG_ALE_MODE   = 1'b0;
    localparam logic CFG_DIMENSIONS = 1'b1;

    typedef enum logic [1:0] {
        ALE_PASS  = 2'd0,
        ALE_RIGID = 2'd1,
        ALE_UNIT  = 2'd2,
        ALE_FULL  = 2'd3
    } ale_mode_t;

    localparam logic [1:0] DIMS_2D = 2'd2;
    localparam logic [1:0] DIMS_3D = 2'd3;

    // Input transaction kinds carried on s_tuser.
    localparam logic ITEM_LOAD = 1'b0;
    localparam logic ITEM_ROW  = 1'b1;

    // Request to and response from the shared divider.
    typedef struct packed {
        logic                     start;
        logic signed [PROD_W-1:0] dividend;
        logic signed [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic                     busy;
        logic signed [PROD_W-1:0] quotient;
    } div_rsp_t;

    // Four geometry slots of one 3D cofactor: C = a*b - c*d.
    typedef struct packed {
        slot_t a;
        slot_t b;
        slot_t c;
        slot_t d;
    } cof_taps_t;

    // One 2D cofactor is a single geometry entry, possibly negated.
    typedef struct packed {
        slot_t slot;
        logic  neg;
    } cof2_tap_t;

    // Index k is 3*m + i for cofactor C(m,i); G(r,c) sits in slot r + 3c.
    function automatic cof_taps_t cof3_taps(input logic [3:0] k);
        cof_taps_t t;
        case (k)
            4'd0:    t = '{a: 4'd4, b: 4'd8, c: 4'd7, d: 4'd5};
            4'd1:    t = '{a: 4'd7, b: 4'd2, c: 4'd1, d: 4'd8};
            4'd2:    t = '{a: 4'd1, b: 4'd5, c: 4'd4, d: 4'd2};
            4'd3:    t = '{a: 4'd6, b: 4'd5, c: 4'd3, d: 4'd8};
            4'd4:    t = '{a: 4'd0, b: 4'd8, c: 4'd6, d: 4'd2};
            4'd5:    t = '{a: 4'd3, b: 4'd2, c: 4'd0, d: 4'd5};
            4'd6:    t = '{a: 4'd3, b: 4'd7, c: 4'd6, d: 4'd4};
            4'd7:    t = '{a: 4'd6, b: 4'd1, c: 4'd0, d: 4'd7};
            4'd8:    t = '{a: 4'd0, b: 4'd4, c: 4'd3, d: 4'd1};
            default: t = '{a: 4'd0, b: 4'd0, c: 4'd0, d: 4'd0};
        endcase
        return t;
    endfunction

    // In 2D, G(r,c) sits in slot r + 2c.
    function automatic cof2_tap_t cof2_tap(input logic [3:0] k);
        cof2_tap_t t;
        case (k)
            4'd0:    t = '{slot: 4'd3, neg: 1'b0};
            4'd1:    t = '{slot: 4'd1, neg: 1'b1};
            4'd3:    t = '{slot: 4'd2, neg: 1'b1};
            4'd4:    t = '{slot: 4'd0, neg: 1'b0};
            default: t = '{slot: 4'd0, neg: 1'b0};
        endcase
        return t;
    endfunction

endpackage

[design/ale_flux_correction.sv]
// ALE flux row correction, top level. Depends on afc_pkg, afc_geo_store,
// afc_mul and afc_div.
//
// Usage: geometry (G column-major, g, V) is loaded with s_tuser = 0 transactions,
// one entry each; these produce no output. A flux row is sent with s_tuser = 1
// and produces one m_ transaction with the corrected row, and m_tuser set when
// the full mode finds a zero determinant (the row is then zero). The mode and
// dimension registers are to be written through cfg_we only while idle; the
// block itself does not enforce this. s_tready is high only while the sequencer
// is idle. In the rigid and cofactor modes the time per row is set by the shared
// divider, which is used once per direction for the rigid term and once per
// cofactor coefficient. The result sits in an output register, so the next row
// is accepted while it waits; if the receiver stalls, a finished second row
// holds in the sequencer until the output register frees. Reset clears the
// control state and sets the registers to pass mode and 3D; the geometry store
// is not cleared and must be loaded before use.
`timescale 1ns / 1ps

module ale_flux_correction #(
    parameter int FRAC_BITS = 16,
    parameter int MAX_DIM   = 3
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [1:0]                      cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_index[3:0], entry_value[35:4], conserved_value[67:36],
    // flux_x[99:68], flux_y[131:100], flux_z[163:132], zero fill above
    input  logic [afc_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode[0]: 0 load geometry entry, 1 flux row
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [afc_pkg::M_TDATA_W-1:0]   m_tdata,
    // divide_error[0]
    output logic                            m_tuser
);
    import afc_pkg::*;

    localparam int OFS_IDX  = 0;
    localparam int OFS_VAL  = 4;
    localparam int OFS_U    = 36;
    localparam int OFS_FX   = 68;
    localparam int OFS_FY   = 100;
    localparam int OFS_FZ   = 132;

    localparam logic signed [DATA_W-1:0] ONE_Q  = DATA_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [PROD_W-1:0] HALF_Q = 64'sd1 <<< (FRAC_BITS - 1);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_G_CHECK,
        ST_RV_ADDR,
        ST_RV_MUL,
        ST_RV_DIV,
        ST_RV_WAIT,
        ST_RIGID_END,
        ST_CF_A,
        ST_CF_2D,
        ST_CF_B,
        ST_CF_M1,
        ST_CF_C,
        ST_CF_M2,
        ST_CF_SUB,
        ST_CO_DIV,
        ST_CO_WAIT,
        ST_CO_MUL,
        ST_CO_ACC,
        ST_FIN_MUL,
        ST_FIN_RND,
        ST_DONE
    } state_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W:0] v);
        if (v > 65'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -65'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[DATA_W-1:0];
    endfunction

    // Round half up to FRAC_BITS fraction bits (floor of p + 1/2).
    function automatic logic signed [PROD_W-1:0] rnd_q(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] v;
        v = p + HALF_Q;
        return v >>> FRAC_BITS;
    endfunction

    state_t                   state_reg, state_next;
    ale_mode_t                ale_mode_reg, ale_mode_next;
    logic [1:0]               dim_reg, dim_next;
    logic signed [DATA_W-1:0] u_reg, u_next;
    logic signed [DATA_W-1:0] f_reg [3];
    logic signed [DATA_W-1:0] f_next [3];
    logic signed [DATA_W-1:0] res_reg [3];
    logic signed [DATA_W-1:0] res_next [3];
    logic                     err_reg, err_next;
    logic signed [DATA_W-1:0] gd_reg, gd_next;
    logic [1:0]               m_reg, m_next;
    logic [1:0]               i_reg, i_next;
    logic signed [DATA_W-1:0] opa_reg, opa_next;
    logic signed [PROD_W-1:0] tmp_reg, tmp_next;
    logic signed [DATA_W-1:0] cof_reg, cof_next;
    logic signed [DATA_W-1:0] coef_reg, coef_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]     m_tdata_reg, m_tdata_next;
    logic                     m_tuser_reg, m_tuser_next;

    logic                     s_accept;
    logic                     nd3;
    logic [1:0]               last_dir;
    logic [3:0]               tap_k;
    cof_taps_t                taps3;
    cof2_tap_t                tap2;
    slot_t                    rd_addr;
    logic signed [DATA_W-1:0] rd_data;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    logic signed [DATA_W-1:0] in_fx, in_fy, in_fz, in_u;
    logic signed [DATA_W-1:0] fm;
    logic signed [DATA_W-1:0] gd_sel;
    logic signed [PROD_W-1:0] mul_rnd;
    logic signed [PROD_W:0]   rig_diff;
    logic signed [PROD_W:0]   cof3_diff;
    logic signed [PROD_W:0]   neg_rd;
    logic signed [DATA_W-1:0] acc_sat;

    assign s_accept = s_tvalid && s_tready;
    assign nd3      = (dim_reg == DIMS_3D) && (MAX_DIM >= 3);
    assign last_dir = nd3 ? 2'd2 : 2'd1;
    assign tap_k    = ({2'b00, m_reg} * 4'd3) + {2'b00, i_reg};
    assign taps3    = cof3_taps(tap_k);
    assign tap2     = cof2_tap(tap_k);

    assign in_u  = s_tdata[OFS_U +: DATA_W];
    assign in_fx = s_tdata[OFS_FX +: DATA_W];
    assign in_fy = s_tdata[OFS_FY +: DATA_W];
    assign in_fz = nd3 ? s_tdata[OFS_FZ +: DATA_W] : '0;

    assign fm        = f_reg[m_reg];
    assign gd_sel    = (ale_mode_reg == ALE_FULL) ? rd_data : ONE_Q;
    assign mul_rnd   = rnd_q(mul_p);
    assign rig_diff  = {{(PROD_W-DATA_W+1){fm[DATA_W-1]}}, fm}
                     - {div_rsp.quotient[PROD_W-1], div_rsp.quotient};
    assign cof3_diff = {tmp_reg[PROD_W-1], tmp_reg} - {mul_rnd[PROD_W-1], mul_rnd};
    assign neg_rd    = (PROD_W + 1)'(0) - {{(PROD_W-DATA_W+1){rd_data[DATA_W-1]}}, rd_data};
    assign acc_sat   = sat32({acc_reg[PROD_W-1], acc_reg});

    afc_geo_store u_store (
        .aclk  (aclk),
        .we    (s_accept && (s_tuser == ITEM_LOAD)),
        .waddr (s_tdata[OFS_IDX +: SLOT_W]),
        .wdata (s_tdata[OFS_VAL +: DATA_W]),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    afc_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    afc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Store address, multiplier operands and divider request by sequencer step.
    always_comb begin
        rd_addr          = SLOT_G;
        mul_a            = '0;
        mul_b            = '0;
        div_req.start    = 1'b0;
        div_req.dividend = mul_p;
        div_req.divisor  = gd_reg;
        case (state_reg)
            ST_RV_ADDR: rd_addr = slot_t'(SLOT_V + {2'b00, m_reg});
            ST_RV_MUL: begin
                mul_a = u_reg;
                mul_b = rd_data;
            end
            ST_RV_DIV:  div_req.start = 1'b1;
            ST_CF_A:    rd_addr = nd3 ? taps3.a : tap2.slot;
            ST_CF_B:    rd_addr = taps3.b;
            ST_CF_M1: begin
                mul_a   = opa_reg;
                mul_b   = rd_data;
                rd_addr = taps3.c;
            end
            ST_CF_C:    rd_addr = taps3.d;
            ST_CF_M2: begin
                mul_a = opa_reg;
                mul_b = rd_data;
            end
            ST_CO_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = $signed({{(PROD_W-DATA_W){cof_reg[DATA_W-1]}}, cof_reg})
                                   <<< FRAC_BITS;
            end
            ST_CO_MUL: begin
                mul_a = fm;
                mul_b = coef_reg;
            end
            ST_FIN_MUL: begin
                mul_a = gd_reg;
                mul_b = acc_sat;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        ale_mode_next = ale_mode_reg;
        dim_next      = dim_reg;
        u_next        = u_reg;
        f_next        = f_reg;
        res_next      = res_reg;
        err_next      = err_reg;
        gd_next       = gd_reg;
        m_next        = m_reg;
        i_next        = i_reg;
        opa_next      = opa_reg;
        tmp_next      = tmp_reg;
        cof_next      = cof_reg;
        coef_next     = coef_reg;
        acc_next      = acc_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (cfg_we) begin
            if (cfg_index == CFG_ALE_MODE) begin
                ale_mode_next = ale_mode_t'(cfg_data);
            end else if (cfg_index == CFG_DIMENSIONS) begin
                dim_next = cfg_data;
            end
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_tuser == ITEM_ROW)) begin
                    u_next      = in_u;
                    f_next[0]   = in_fx;
                    f_next[1]   = in_fy;
                    f_next[2]   = in_fz;
                    err_next    = 1'b0;
                    m_next      = 2'd0;
                    i_next      = 2'd0;
                    if (ale_mode_reg == ALE_PASS) begin
                        res_next[0] = in_fx;
                        res_next[1] = in_fy;
                        res_next[2] = in_fz;
                        state_next  = ST_DONE;
                    end else begin
                        res_next[0] = '0;
                        res_next[1] = '0;
                        res_next[2] = '0;
                        state_next  = ST_G_CHECK;
                    end
                end
            end
            ST_G_CHECK: begin
                gd_next = gd_sel;
                if (gd_sel == '0) begin
                    err_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_RV_ADDR;
                end
            end
            ST_RV_ADDR: state_next = ST_RV_MUL;
            ST_RV_MUL:  state_next = ST_RV_DIV;
            ST_RV_DIV:  state_next = ST_RV_WAIT;
            ST_RV_WAIT: begin
                if (div_rsp.done) begin
                    f_next[m_reg] = sat32(rig_diff);
                    if (m_reg == last_dir) begin
                        m_next     = 2'd0;
                        state_next = ST_RIGID_END;
                    end else begin
                        m_next     = m_reg + 2'd1;
                        state_next = ST_RV_ADDR;
                    end
                end
            end
            ST_RIGID_END: begin
                acc_next = '0;
                if (ale_mode_reg == ALE_RIGID) begin
                    res_next   = f_reg;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_CF_A;
                end
            end
            ST_CF_A:   state_next = nd3 ? ST_CF_B : ST_CF_2D;
            ST_CF_2D: begin
                cof_next   = tap2.neg ? sat32(neg_rd) : rd_data;
                state_next = ST_CO_DIV;
            end
            ST_CF_B: begin
                opa_next   = rd_data;
                state_next = ST_CF_M1;
            end
            ST_CF_M1:  state_next = ST_CF_C;
            ST_CF_C: begin
                tmp_next   = mul_rnd;
                opa_next   = rd_data;
                state_next = ST_CF_M2;
            end
            ST_CF_M2:  state_next = ST_CF_SUB;
            ST_CF_SUB: begin
                cof_next   = sat32(cof3_diff);
                state_next = ST_CO_DIV;
            end
            ST_CO_DIV: state_next = ST_CO_WAIT;
            ST_CO_WAIT: begin
                if (div_rsp.done) begin
                    coef_next  = sat32({div_rsp.quotient[PROD_W-1], div_rsp.quotient});
                    state_next = ST_CO_MUL;
                end
            end
            ST_CO_MUL: state_next = ST_CO_ACC;
            ST_CO_ACC: begin
                acc_next = acc_reg + mul_rnd;
                if (m_reg == last_dir) begin
                    state_next = ST_FIN_MUL;
                end else begin
                    m_next     = m_reg + 2'd1;
                    state_next = ST_CF_A;
                end
            end
            ST_FIN_MUL: state_next = ST_FIN_RND;
            ST_FIN_RND: begin
                res_next[i_reg] = sat32({mul_rnd[PROD_W-1], mul_rnd});
                m_next          = 2'd0;
                acc_next        = '0;
                if (i_reg == last_dir) begin
                    state_next = ST_DONE;
                end else begin
                    i_next     = i_reg + 2'd1;
                    state_next = ST_CF_A;
                end
            end
            ST_DONE: begin
                // Hand the row to the output register once it is free.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = err_reg ? '0 : {res_reg[2], res_reg[1], res_reg[0]};
                    m_tuser_next  = err_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ale_mode_reg <= ALE_PASS;
            dim_reg      <= DIMS_3D;
            m_tvalid_reg <= 1'b0;
            m_reg        <= 2'd0;
            i_reg        <= 2'd0;
        end else begin
            state_reg    <= state_next;
            ale_mode_reg <= ale_mode_next;
            dim_reg      <= dim_next;
            m_tvalid_reg <= m_tvalid_next;
            m_reg        <= m_next;
            i_reg        <= i_next;
        end
        u_reg       <= u_next;
        f_reg       <= f_next;
        res_reg     <= res_next;
        err_reg     <= err_next;
        gd_reg      <= gd_next;
        opa_reg     <= opa_next;
        tmp_reg     <= tmp_next;
        cof_reg     <= cof_next;
        coef_reg    <= coef_next;
        acc_reg     <= acc_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A zero-determinant result always carries an all-zero row.
    a_err_zero_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("divide error with nonzero row");

    // Only the full mode divides by the stored determinant.
    a_err_full_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (ale_mode_reg == ALE_FULL))
        else $error("divide error outside full mode");

    // The shared divider is quiet whenever a new transaction can be taken.
    a_idle_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_rsp.busy)
        else $error("divider busy while idle");

    // In 2D the third direction of every result is zero.
    a_2d_z_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !nd3) |-> (m_tdata[M_TDATA_W-1 -: DATA_W] == '0))
        else $error("nonzero z output in 2D");

endmodule

[design/afc_mul.sv]
// Shared 32 x 32 signed multiplier with a registered product.
// Depends on afc_pkg for the operand and product widths.
`timescale 1ns / 1ps

module afc_mul (
    input  logic                              aclk,
    input  logic signed [afc_pkg::DATA_W-1:0] a,
    input  logic signed [afc_pkg::DATA_W-1:0] b,
    output logic signed [afc_pkg::PROD_W-1:0] p
);
    import afc_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

[design/afc_div.sv]
// Shared iterative signed divider, one quotient bit per cycle, quotient
// truncated toward zero. Depends on afc_pkg for widths and request types.
`timescale 1ns / 1ps

module afc_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  afc_pkg::div_req_t req,
    output afc_pkg::div_rsp_t rsp
);
    import afc_pkg::*;

    localparam int STEPS = PROD_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [DATA_W:0]   rem_shift;

    assign rem_shift = {rem_reg, quo_reg[PROD_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS);
            neg_next  = req.dividend[PROD_W-1] ^ req.divisor[DATA_W-1];
            quo_next  = req.dividend[PROD_W-1] ? (~$unsigned(req.dividend) + 1'b1)
                                               : $unsigned(req.dividend);
            dvs_next  = req.divisor[DATA_W-1] ? (~$unsigned(req.divisor) + 1'b1)
                                              : $unsigned(req.divisor);
            rem_next  = '0;
        end else if (busy_reg) begin
            // Restoring step on the magnitudes; the dividend shifts out of quo_reg
            // while quotient bits shift in from the bottom.
            if (rem_shift >= {1'b0, dvs_reg}) begin
                rem_next = DATA_W'(rem_shift - {1'b0, dvs_reg});
                quo_next = {quo_reg[PROD_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[DATA_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.busy     = busy_reg;
    assign rsp.quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    // A new division must never be started on top of one in progress.
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

[design/afc_geo_store.sv]
// Geometry store: 13 words of G, g and V, one write and one registered read port.
// Depends on afc_pkg for the depth, word width and slot type.
`timescale 1ns / 1ps

module afc_geo_store (
    input  logic                              aclk,
    input  logic                              we,
    input  afc_pkg::slot_t                    waddr,
    input  logic signed [afc_pkg::DATA_W-1:0] wdata,
    input  afc_pkg::slot_t                    raddr,
    output logic signed [afc_pkg::DATA_W-1:0] rdata
);
    import afc_pkg::*;

    logic signed [DATA_W-1:0] mem [GEO_DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;

    // Writes to slots past the end of the store are dropped.
    always_ff @(posedge aclk) begin
        if (we && (waddr < SLOT_W'(GEO_DEPTH))) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
